// ----- rtl/core/text_console_cursor_engine_assert.svh -----
// ----------------------------------------------------------------------------
// Text console cursor engine assertion macros
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset
`define TCCE_ASSERT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define TCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define TCCE_ASSERT(lbl, clk, rst_n, cond, msg)
`define TCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Field widths, screen geometry defaults and control character codes.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 11;

  // Screen geometry defaults
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Cells a tab advances
  localparam int TAB_STEP = 4;

  // Control character codes
  localparam logic [CHAR_W-1:0] CODE_NULL      = 8'h00;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LINE_FEED = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;

endpackage

// ----- rtl/core/tcce_char_if.sv -----
// ----------------------------------------------------------------------------
// Character request channel
// Valid/ready channel that carries one character byte per request.
// ----------------------------------------------------------------------------
interface tcce_char_if
  import tcce_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);

endinterface

// ----- rtl/core/tcce_res_if.sv -----
// ----------------------------------------------------------------------------
// Cursor result channel
// Valid/ready channel that carries the cell write and cursor of one request.
// ----------------------------------------------------------------------------
interface tcce_res_if
  import tcce_pkg::*;
();

  logic              valid;
  logic              ready;
  logic              write_enable;
  logic [CELL_W-1:0] write_cell;
  logic [CHAR_W-1:0] write_char;
  logic              scroll_up;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_column;

  modport source (
    output valid, output write_enable, output write_cell, output write_char,
    output scroll_up, output cursor_row, output cursor_column,
    input ready
  );
  modport sink (
    input valid, input write_enable, input write_cell, input write_char,
    input scroll_up, input cursor_row, input cursor_column,
    output ready
  );

endinterface

// ----- rtl/core/text_console_cursor_engine.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine
// A request passes from the registered input stage to the registered result stage.
// Throughput: one request per cycle while the sink takes each result; the cursor update is combinational.
// Both stages stall only while a result waits for the sink to take it.
// Reset clears the cursor to row 0, column 0 and empties both stages.
// ----------------------------------------------------------------------------
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS    = ROWS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcce_char_if.sink    char_i,
  tcce_res_if.source   res_o
);

  `include "text_console_cursor_engine_assert.svh"

  localparam int FULL_W = ROW_W + COL_W;

  localparam logic [COL_W:0]   ColLimit = (COL_W+1)'(COLUMNS);
  localparam logic [COL_W-1:0] ColLast  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W:0]   RowLimit = (ROW_W+1)'(ROWS);
  localparam logic [COL_W:0]   TabInc   = (COL_W+1)'(TAB_STEP);

  // Input stage
  logic              in_valid_q;
  logic [CHAR_W-1:0] in_char_q;

  // Cursor state
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;

  // Result stage
  logic              out_valid_q;
  logic              wr_en_q, wr_en_d;
  logic [CELL_W-1:0] wr_cell_q, wr_cell_d;
  logic [CHAR_W-1:0] wr_char_q, wr_char_d;
  logic              scroll_q, scroll_d;

  // Handshake
  logic out_load;
  logic in_take;

  // Datapath helpers
  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    col_tab;
  logic [ROW_W:0]    row_inc;
  logic [FULL_W-1:0] cell_full;

  assign out_load     = in_valid_q && (!out_valid_q || res_o.ready);
  assign char_i.ready = !in_valid_q || out_load;
  assign in_take      = char_i.valid && char_i.ready;

  // Hold the accepted byte in the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= char_i.char_code;
    end
  end

  // Compute the next cursor and the cell write
  always_comb begin
    col_inc   = {1'b0, col_q} + 1'b1;
    col_tab   = {1'b0, col_q} + TabInc;
    row_inc   = {1'b0, row_q} + 1'b1;
    cell_full = FULL_W'(row_q) * FULL_W'(COLUMNS) + FULL_W'(col_q);

    row_d     = row_q;
    col_d     = col_q;
    wr_en_d   = 1'b0;
    wr_cell_d = '0;
    wr_char_d = '0;
    scroll_d  = 1'b0;

    case (in_char_q)
      CODE_NULL: begin
        // ignore
      end
      CODE_BACKSPACE: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end else if (row_q != '0) begin
          row_d = row_q - 1'b1;
          col_d = ColLast;
        end
      end
      CODE_TAB: begin
        if (col_tab >= ColLimit) begin
          col_d = COL_W'(col_tab - ColLimit);
          if (row_inc == RowLimit) begin
            scroll_d = 1'b1;
          end else begin
            row_d = row_inc[ROW_W-1:0];
          end
        end else begin
          col_d = col_tab[COL_W-1:0];
        end
      end
      CODE_LINE_FEED: begin
        if (row_inc == RowLimit) begin
          scroll_d = 1'b1;
        end else begin
          row_d = row_inc[ROW_W-1:0];
        end
      end
      CODE_RETURN: begin
        col_d = '0;
      end
      default: begin
        // any other byte: store it, then advance one cell
        wr_en_d   = 1'b1;
        wr_cell_d = cell_full[CELL_W-1:0];
        wr_char_d = in_char_q;
        if (col_inc == ColLimit) begin
          col_d = '0;
          if (row_inc == RowLimit) begin
            scroll_d = 1'b1;
          end else begin
            row_d = row_inc[ROW_W-1:0];
          end
        end else begin
          col_d = col_inc[COL_W-1:0];
        end
      end
    endcase
  end

  // Advance the cursor as each request moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (out_load) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      wr_en_q   <= wr_en_d;
      wr_cell_q <= wr_cell_d;
      wr_char_q <= wr_char_d;
      scroll_q  <= scroll_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.write_enable  = wr_en_q;
  assign res_o.write_cell    = wr_cell_q;
  assign res_o.write_char    = wr_char_q;
  assign res_o.scroll_up     = scroll_q;
  assign res_o.cursor_row    = row_q;
  assign res_o.cursor_column = col_q;

  // Checks
  `TCCE_ASSERT(a_cursor_on_screen, clk_i, rst_ni, ({1'b0, row_q} < RowLimit) && ({1'b0, col_q} < ColLimit), "cursor left the screen")
  `TCCE_ASSERT_IMP(a_scroll_last_row, clk_i, rst_ni, out_valid_q && scroll_q, {1'b0, row_q} == RowLimit - 1'b1, "scroll without cursor on last row")
  `TCCE_ASSERT_IMP(a_idle_write_zero, clk_i, rst_ni, out_valid_q && !wr_en_q, (wr_cell_q == '0) && (wr_char_q == '0), "write fields set without a write")
  `TCCE_ASSERT_IMP(a_cursor_holds, clk_i, rst_ni, !out_load, ##1 ($stable(row_q) && $stable(col_q)), "cursor moved without a request")

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Streams character requests into the cursor engine and checks every cell
// write, scroll flag and cursor position against a cycle-free predictor,
// with random idling on both channels, a long sink hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench
  import tcce_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_COLS   = COLUMNS_DEFAULT;
  localparam int SCREEN_ROWS   = ROWS_DEFAULT;
  localparam int RANDOM_CHARS  = 1530;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic              write_enable;
    logic [CELL_W-1:0] write_cell;
    logic [CHAR_W-1:0] write_char;
    logic              scroll_up;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
  } cursor_result_t;

  // Cursor predictor and queue of expected cursor results
  class cursor_scoreboard;
    int unsigned    cur_row;
    int unsigned    cur_col;
    cursor_result_t expected_cursor_q[$];
    int unsigned    mismatch_count;

    function new();
      cur_row        = 0;
      cur_col        = 0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return expected_cursor_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // Advance the cursor for one accepted character request
    function void note_char(logic [CHAR_W-1:0] code);
      cursor_result_t want;
      int unsigned    cells;
      int unsigned    offset;
      bit             wrap_check;
      cells      = SCREEN_COLS * SCREEN_ROWS;
      offset     = cur_row * SCREEN_COLS + cur_col;
      wrap_check = 1'b0;
      want       = '0;
      if (offset >= cells) offset = cells - 1;
      case (code)
        CODE_BACKSPACE: begin
          if (offset > 0) offset--;
        end
        CODE_TAB: begin
          offset += TAB_STEP;
          wrap_check = 1'b1;
        end
        CODE_LINE_FEED: begin
          offset += SCREEN_COLS;
          wrap_check = 1'b1;
        end
        CODE_RETURN: begin
          offset -= offset % SCREEN_COLS;
        end
        CODE_NULL: begin
        end
        default: begin
          want.write_enable = 1'b1;
          want.write_cell   = offset[CELL_W-1:0];
          want.write_char   = code;
          offset++;
          wrap_check = 1'b1;
        end
      endcase
      // Pull the cursor up one row once it runs past the last cell
      if (wrap_check && offset >= cells) begin
        offset -= SCREEN_COLS;
        want.scroll_up = 1'b1;
        if (offset >= cells) offset = cells - 1;
      end
      cur_row = offset / SCREEN_COLS;
      cur_col = offset % SCREEN_COLS;
      want.cursor_row    = cur_row[ROW_W-1:0];
      want.cursor_column = cur_col[COL_W-1:0];
      expected_cursor_q.push_back(want);
    endfunction

    // Compare one result with the oldest expectation
    task check_result(cursor_result_t got);
      cursor_result_t want;
      if (expected_cursor_q.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
      end else begin
        want = expected_cursor_q.pop_front();
        if (got.write_enable !== want.write_enable)
          report($sformatf("write_enable %0b, want %0b", got.write_enable, want.write_enable));
        if (got.write_cell !== want.write_cell)
          report($sformatf("write_cell %0d, want %0d", got.write_cell, want.write_cell));
        if (got.write_char !== want.write_char)
          report($sformatf("write_char %02h, want %02h", got.write_char, want.write_char));
        if (got.scroll_up !== want.scroll_up)
          report($sformatf("scroll_up %0b, want %0b", got.scroll_up, want.scroll_up));
        if (got.cursor_row !== want.cursor_row)
          report($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
        if (got.cursor_column !== want.cursor_column)
          report($sformatf("cursor_column %0d, want %0d", got.cursor_column,
                           want.cursor_column));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tcce_char_if char_src ();
  tcce_res_if  cursor_res ();

  cursor_scoreboard cursor_sb = new();

  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned sink_hold_cycles;
  int unsigned chars_sent;
  int unsigned cycle_count;

  text_console_cursor_engine DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_src.sink),
    .res_o  (cursor_res.source)
  );

  // Clock generator
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Note every accepted character request
  always @(posedge clk) begin
    if (rst_n && char_src.valid && char_src.ready) cursor_sb.note_char(char_src.char_code);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && cursor_res.valid && cursor_res.ready)
      cursor_sb.check_result({cursor_res.write_enable, cursor_res.write_cell,
                              cursor_res.write_char, cursor_res.scroll_up,
                              cursor_res.cursor_row, cursor_res.cursor_column});
  end

  // Abort a run that stops making progress
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result sink: random stalls, plus a long hold-off when one is requested
  initial begin : result_sink
    int unsigned stall;
    cursor_res.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 6) : 0;
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        cursor_res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      cursor_res.ready <= 1'b1;
      do @(posedge clk); while (!cursor_res.valid);
    end
  end

  // Offer one character request and hold it until accepted
  task automatic send_char(logic [CHAR_W-1:0] code);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      char_src.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_src.valid     <= 1'b1;
    char_src.char_code <= code;
    do @(posedge clk); while (!char_src.ready);
    chars_sent++;
  endtask

  // Hold the source until every expected result has come back
  task automatic wait_drained();
    char_src.valid <= 1'b0;
    // Wait for a clock edge so the last accepted request is already noted
    @(posedge clk);
    while (cursor_sb.pending() > 0) @(posedge clk);
  endtask

  // Send one random burst shaped after typical console traffic
  task automatic send_random_burst();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        len = $urandom_range(1, 90);
        repeat (len) send_char(8'($urandom_range(14, 255)));
      end
      4, 5: begin
        len = $urandom_range(1, 30);
        repeat (len) send_char(CODE_LINE_FEED);
      end
      6: begin
        len = $urandom_range(1, 25);
        repeat (len) send_char(CODE_TAB);
      end
      7: begin
        send_char(8'($urandom_range(0, 255)));
      end
      8: begin
        send_char($urandom_range(0, 1) ? CODE_RETURN : CODE_NULL);
      end
      default: begin
        len = $urandom_range(1, 85);
        repeat (len) send_char(CODE_BACKSPACE);
      end
    endcase
  endtask

  // Main sequence
  initial begin : stimulus
    bit          hold_done;
    bit          drain_done;
    int unsigned next_switch;
    rst_n              <= 1'b0;
    char_src.valid     <= 1'b0;
    char_src.char_code <= '0;
    src_idle_on        = 1'b0;
    sink_idle_on       = 1'b0;
    sink_hold_cycles   = 0;
    chars_sent         = 0;
    cycle_count        = 0;
    hold_done          = 1'b0;
    drain_done         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: controls at the origin, byte extremes, every control code
    send_char(CODE_BACKSPACE);
    send_char(CODE_NULL);
    send_char(CODE_RETURN);
    send_char(8'h41);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h01);
    send_char(8'h7F);
    send_char(CODE_TAB);
    send_char(CODE_RETURN);
    send_char(CODE_LINE_FEED);
    // Backspace at column zero wraps to the last column of the row above
    send_char(CODE_BACKSPACE);
    send_char(8'h55);
    send_char(CODE_TAB);
    send_char(8'hAA);
    send_char(CODE_LINE_FEED);
    send_char(CODE_NULL);
    send_char(8'h20);
    send_char(CODE_RETURN);
    send_char(CODE_BACKSPACE);
    wait_drained();

    // Random bursts with changing idle patterns
    next_switch = chars_sent;
    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= next_switch) begin
        src_idle_on  = $urandom_range(0, 2) != 0;
        sink_idle_on = $urandom_range(0, 2) != 0;
        next_switch  = chars_sent + $urandom_range(60, 200);
      end
      // Stall the sink for a long stretch while the source keeps pushing
      if (!hold_done && chars_sent >= 400) begin
        hold_done        = 1'b1;
        src_idle_on      = 1'b0;
        sink_hold_cycles = 150;
      end
      // Pause the source until the engine is empty
      if (!drain_done && chars_sent >= 900) begin
        drain_done = 1'b1;
        wait_drained();
      end
      send_random_burst();
    end

    // Drain and settle
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (cursor_sb.mismatch_count == 0 && cursor_sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_char_if.sv
rtl/core/tcce_res_if.sv
rtl/core/text_console_cursor_engine.sv
tb/sv/testbench.sv
